/* rtl/flvd_pkg.sv */
package flvd_pkg;

   typedef enum logic [1:0] {
      PH_FILE_HDR,
      PH_TAG_HDR,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   localparam logic [23:0] FILE_HDR_LEN = 24'd13;
   localparam logic [23:0] TAG_HDR_LAST = 24'd10;
   localparam logic [23:0] SIZE_LAST_BYTE = 24'd3;
   localparam logic [23:0] TIME_LAST_BYTE = 24'd6;
   localparam logic [23:0] TRAILER_LEN = 24'd4;
   localparam logic [7:0] TYPE_AUDIO = 8'h08;
   localparam logic [7:0] TYPE_VIDEO = 8'h09;

   typedef struct packed {
      logic [7:0] data_byte;
      logic stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic tag_kind;
      logic [23:0] timestamp;
      logic first_of_tag;
      logic last_of_tag;
      logic empty_tag;
      logic truncated;
   } rsp_type;

endpackage

/* rtl/flvd_parse.sv */
module flvd_parse (
   input logic clock,
   input logic reset,
   input logic step,
   input flvd_pkg::req_type item,
   input logic [23:0] seek_timestamp,
   output logic res_valid,
   output flvd_pkg::rsp_type res
);

   flvd_pkg::phase_type phase_ff, phase_in;
   logic [23:0] count_ff, count_in;
   logic [7:0] type_ff, type_in;
   logic [23:0] size_ff, size_in;
   logic [23:0] time_ff, time_in;
   logic sat_ff, sat_in;

   logic is_av;
   logic kind;
   logic sat_next;
   logic acc;
   logic last;
   logic [23:0] count_inc;

   always_comb begin
      is_av = (type_ff == flvd_pkg::TYPE_AUDIO) || (type_ff == flvd_pkg::TYPE_VIDEO);
      kind = (type_ff == flvd_pkg::TYPE_VIDEO);
      sat_next = sat_ff || (is_av && (time_ff >= seek_timestamp));
      acc = is_av && sat_next;
      count_inc = count_ff + 24'd1;
      last = (count_inc >= size_ff);

      phase_in = phase_ff;
      count_in = count_ff;
      type_in = type_ff;
      size_in = size_ff;
      time_in = time_ff;
      sat_in = sat_ff;
      res_valid = 1'b0;
      res = '0;

      case (phase_ff)
         flvd_pkg::PH_FILE_HDR: begin
            count_in = count_inc;
            if (count_inc >= flvd_pkg::FILE_HDR_LEN) begin
               phase_in = flvd_pkg::PH_TAG_HDR;
               count_in = '0;
            end
         end
         flvd_pkg::PH_TAG_HDR: begin
            if (count_ff == '0) begin
               type_in = item.data_byte;
            end else if (count_ff <= flvd_pkg::SIZE_LAST_BYTE) begin
               size_in = {size_ff[15:0], item.data_byte};
            end else if (count_ff <= flvd_pkg::TIME_LAST_BYTE) begin
               time_in = {time_ff[15:0], item.data_byte};
            end
            if (count_ff < flvd_pkg::TAG_HDR_LAST) begin
               count_in = count_inc;
               if (item.stream_end) begin
                  res_valid = 1'b1;
                  res.first_of_tag = 1'b1;
                  res.truncated = 1'b1;
               end
            end else begin
               sat_in = sat_next;
               count_in = '0;
               res.tag_kind = kind;
               res.timestamp = time_ff;
               res.first_of_tag = 1'b1;
               if (size_ff == '0) begin
                  res_valid = acc;
                  res.last_of_tag = 1'b1;
                  res.empty_tag = 1'b1;
                  phase_in = flvd_pkg::PH_TRAILER;
               end else begin
                  res_valid = acc && item.stream_end;
                  res.truncated = 1'b1;
                  phase_in = flvd_pkg::PH_PAYLOAD;
               end
            end
         end
         flvd_pkg::PH_PAYLOAD: begin
            res_valid = is_av && sat_ff;
            res.payload_byte = item.data_byte;
            res.tag_kind = kind;
            res.timestamp = time_ff;
            res.first_of_tag = (count_ff == '0);
            res.last_of_tag = last;
            res.truncated = item.stream_end && !last;
            if (last) begin
               phase_in = flvd_pkg::PH_TRAILER;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         flvd_pkg::PH_TRAILER: begin
            count_in = count_inc;
            if (count_inc >= flvd_pkg::TRAILER_LEN) begin
               phase_in = flvd_pkg::PH_TAG_HDR;
               count_in = '0;
               type_in = '0;
               size_in = '0;
               time_in = '0;
            end
         end
         default: begin
            phase_in = flvd_pkg::PH_FILE_HDR;
         end
      endcase

      if (item.stream_end) begin
         phase_in = flvd_pkg::PH_FILE_HDR;
         count_in = '0;
         type_in = '0;
         size_in = '0;
         time_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= flvd_pkg::PH_FILE_HDR;
         count_ff <= '0;
         type_ff <= '0;
         size_ff <= '0;
         time_ff <= '0;
         sat_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         type_ff <= type_in;
         size_ff <= size_in;
         time_ff <= time_in;
         sat_ff <= sat_in;
      end
   end

endmodule

/* rtl/flv_tag_deframer.sv */
// FLV tag deframer: takes an FLV file one byte per transaction and returns the payload
// bytes of audio and video tags with kind, timestamp and first/last/empty/truncated
// marks. One byte is taken every cycle when the result side keeps up; a byte goes through
// an input register, the parser state update and a result register. Tags are dropped
// until an audio or video tag with a timestamp at or above csr_wdata's last written
// value appears; every stream_end restarts parsing at the file header.
module flv_tag_deframer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input flvd_pkg::req_type req_payload,
   output logic rsp_valid,
   input logic rsp_ready,
   output flvd_pkg::rsp_type rsp_payload,
   input logic csr_we,
   input logic [23:0] csr_wdata
);

   logic [23:0] seek_ff;
   logic in_valid_ff;
   flvd_pkg::req_type in_item_ff;
   logic out_valid_ff, out_valid_in;
   flvd_pkg::rsp_type out_item_ff;

   logic out_free;
   logic step;
   logic res_valid;
   flvd_pkg::rsp_type res;

   assign out_free = !out_valid_ff || rsp_ready;
   assign step = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign out_valid_in = step && res_valid;

   flvd_parse u_parse (
      .clock(clock),
      .reset(reset),
      .step(step),
      .item(in_item_ff),
      .seek_timestamp(seek_ff),
      .res_valid(res_valid),
      .res(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seek_ff <= '0;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seek_ff <= csr_wdata;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (out_free && out_valid_in) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

/* rtl/flvd_checker.sv */
module flvd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input flvd_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.empty_tag |->
         rsp_payload.first_of_tag && rsp_payload.last_of_tag &&
         (rsp_payload.payload_byte == 8'd0) && !rsp_payload.truncated)
      else $error("malformed empty tag result");

   a_trunc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.truncated |-> !rsp_payload.last_of_tag)
      else $error("truncated result marked last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind flv_tag_deframer flvd_checker u_flvd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);
